@@ rtl/core/fctce_pkg.sv @@
// Shared types and constants of the FIR coefficient table command engine.
package fctce_pkg;

  localparam int unsigned LEN_W  = 8;
  localparam int unsigned HALF_W = 16;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    MODE_SET_COEFF  = 2'd0,
    MODE_GET_COEFF  = 2'd1,
    MODE_GET_STATUS = 2'd2,
    MODE_SET_STATUS = 2'd3
  } mode_e;

  localparam logic RESP_COEFF  = 1'b0;
  localparam logic RESP_STATUS = 1'b1;

  typedef struct packed {
    mode_e              mode;
    logic [7:0]         source_node;
    logic [7:0]         filter_sel;
    logic [HALF_W-1:0]  coeff_index;
    logic [HALF_W-1:0]  value_high;
    logic [HALF_W-1:0]  value_low;
    logic               enable;
    logic [HALF_W-1:0]  length;
  } cmd_t;

  typedef struct packed {
    logic               resp_kind;
    logic [7:0]         dest_node;
    logic [7:0]         resp_filter;
    logic [HALF_W-1:0]  resp_index_or_len;
    logic [HALF_W-1:0]  resp_high;
    logic [HALF_W-1:0]  resp_low;
  } resp_t;

  typedef struct packed {
    logic               start;
    logic [LEN_W-1:0]   len;
  } fold_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [WORD_W-1:0]  id;
  } fold_rsp_t;

endpackage

@@ rtl/core/fctce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fctce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/fctce_fold.sv @@
// Iterative XOR fold of a filter's coefficients, one stored word per cycle.
module fctce_fold #(
  parameter int unsigned IdxW = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fctce_pkg::fold_req_t      req_i,
  input  logic [fctce_pkg::WORD_W-1:0] rdata_i,
  output logic [IdxW-1:0]           idx_o,
  output fctce_pkg::fold_rsp_t      rsp_o
);

  logic                          busy_q, busy_d;
  logic                          pend_q, pend_d;
  logic [fctce_pkg::LEN_W-1:0]   cnt_q, cnt_d;
  logic [fctce_pkg::LEN_W-1:0]   len_q, len_d;
  logic [fctce_pkg::WORD_W-1:0]  acc_q, acc_d;
  logic                          issue;
  logic                          done;

  assign issue = busy_q && (cnt_q != len_q);
  assign done  = busy_q && (cnt_q == len_q) && !pend_q;

  always_comb begin
    busy_d = busy_q;
    pend_d = issue;
    cnt_d  = cnt_q;
    len_d  = len_q;
    acc_d  = acc_q;
    if (pend_q) begin
      acc_d = acc_q ^ rdata_i;
    end
    if (issue) begin
      cnt_d = cnt_q + fctce_pkg::LEN_W'(1);
    end
    if (done) begin
      busy_d = 1'b0;
    end
    if (req_i.start) begin
      busy_d = 1'b1;
      pend_d = 1'b0;
      cnt_d  = '0;
      len_d  = req_i.len;
      acc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
      len_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign idx_o      = cnt_q[IdxW-1:0];
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done;
  assign rsp_o.id   = acc_q;

endmodule

@@ rtl/core/fir_coefficient_table_command_engine_unit.sv @@
// Top level of the FIR coefficient table command engine.
// Set coefficient, set status without enable, dropped items: taken back to back.
// Get coefficient and get status: read and response states, then a registered result; no new item until it loads.
// Set status with enable: the input stalls in the fold state while the fold reads one word per cycle.
// Reset clears the sequencer, the output valid and the per-filter status valid bits;
// the coefficient memory is not initialised and needs no clearing pass.
module fir_coefficient_table_command_engine_unit #(
  parameter int unsigned NUM_FILTERS = 8,
  parameter int unsigned MAX_LEN     = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fctce_pkg::cmd_t     in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fctce_pkg::resp_t    out_data_o
);

  localparam int unsigned FW     = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int unsigned IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CDEPTH = 1 << (FW + IW);
  localparam int unsigned FDEPTH = 1 << FW;
  localparam int unsigned LW     = fctce_pkg::LEN_W;
  localparam int unsigned WW     = fctce_pkg::WORD_W;
  localparam int unsigned HW     = fctce_pkg::HALF_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;
  localparam logic [1:0] ST_FOLD = 2'd3;

  logic [1:0]            state_q, state_d;
  fctce_pkg::mode_e      mode_q;
  logic [7:0]            src_q;
  logic [7:0]            filt_q;
  logic [IW-1:0]         idx_q;
  logic [FDEPTH-1:0]     st_valid_q, st_valid_d;
  logic                  out_valid_q, out_valid_d;
  fctce_pkg::resp_t      resp_q, resp_d;

  logic                  accept;
  logic                  filt_ok;
  logic                  idx_ok;
  logic [LW-1:0]         len_sat;
  logic [FW-1:0]         in_filt;
  logic [IW-1:0]         in_idx;
  logic                  out_load;

  logic                  coeff_we;
  logic [FW+IW-1:0]      coeff_raddr;
  logic [WW-1:0]         coeff_rdata;
  logic                  st_we;
  logic [LW:0]           st_rdata;
  logic                  id_we;
  logic [WW-1:0]         id_rdata;
  logic                  st_vld;
  logic [LW-1:0]         len_eff;
  logic                  en_eff;

  logic [IW-1:0]         fold_idx;
  fctce_pkg::fold_req_t  fold_req;
  fctce_pkg::fold_rsp_t  fold_rsp;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign filt_ok = 32'(in_data_i.filter_sel) < NUM_FILTERS;
  assign idx_ok  = 32'(in_data_i.coeff_index) < MAX_LEN;
  assign len_sat = (32'(in_data_i.length) > MAX_LEN) ? LW'(MAX_LEN)
                                                     : in_data_i.length[LW-1:0];
  assign in_filt = in_data_i.filter_sel[FW-1:0];
  assign in_idx  = in_data_i.coeff_index[IW-1:0];

  assign coeff_we = accept && filt_ok && idx_ok
                    && (in_data_i.mode == fctce_pkg::MODE_SET_COEFF);
  assign st_we    = accept && filt_ok
                    && (in_data_i.mode == fctce_pkg::MODE_SET_STATUS);
  assign id_we    = fold_rsp.done;

  assign fold_req.start = st_we && in_data_i.enable;
  assign fold_req.len   = len_sat;

  assign coeff_raddr = (state_q == ST_FOLD) ? {filt_q[FW-1:0], fold_idx}
                                            : {filt_q[FW-1:0], idx_q};

  fctce_ram #(
    .Width (WW),
    .Depth (CDEPTH)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (coeff_we),
    .waddr_i ({in_filt, in_idx}),
    .wdata_i ({in_data_i.value_high, in_data_i.value_low}),
    .raddr_i (coeff_raddr),
    .rdata_o (coeff_rdata)
  );

  fctce_ram #(
    .Width (LW + 1),
    .Depth (FDEPTH)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (in_filt),
    .wdata_i ({len_sat, in_data_i.enable}),
    .raddr_i (filt_q[FW-1:0]),
    .rdata_o (st_rdata)
  );

  fctce_ram #(
    .Width (WW),
    .Depth (FDEPTH)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (filt_q[FW-1:0]),
    .wdata_i (fold_rsp.id),
    .raddr_i (filt_q[FW-1:0]),
    .rdata_o (id_rdata)
  );

  fctce_fold #(
    .IdxW (IW)
  ) u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (fold_req),
    .rdata_i (coeff_rdata),
    .idx_o   (fold_idx),
    .rsp_o   (fold_rsp)
  );

  assign st_vld  = st_valid_q[filt_q[FW-1:0]];
  assign len_eff = st_vld ? st_rdata[LW:1] : '0;
  assign en_eff  = st_vld && st_rdata[0];

  assign out_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && filt_ok) begin
          case (in_data_i.mode)
            fctce_pkg::MODE_GET_COEFF:  if (idx_ok) state_d = ST_READ;
            fctce_pkg::MODE_GET_STATUS: state_d = ST_READ;
            fctce_pkg::MODE_SET_STATUS: if (in_data_i.enable) state_d = ST_FOLD;
            default:                    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_RESP;
      ST_RESP: if (out_load) state_d = ST_IDLE;
      ST_FOLD: if (fold_rsp.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (st_we) begin
      st_valid_d[in_filt] = 1'b1;
    end
  end

  always_comb begin
    resp_d             = resp_q;
    out_valid_d        = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d          = 1'b1;
      resp_d.dest_node     = src_q;
      resp_d.resp_filter   = filt_q;
      case (mode_q)
        fctce_pkg::MODE_GET_COEFF: begin
          resp_d.resp_kind         = fctce_pkg::RESP_COEFF;
          resp_d.resp_index_or_len = HW'(idx_q);
          resp_d.resp_high         = coeff_rdata[WW-1:HW];
          resp_d.resp_low          = coeff_rdata[HW-1:0];
        end
        default: begin
          resp_d.resp_kind         = fctce_pkg::RESP_STATUS;
          resp_d.resp_index_or_len = HW'(len_eff);
          resp_d.resp_high         = en_eff ? id_rdata[WW-1:HW] : '0;
          resp_d.resp_low          = en_eff ? id_rdata[HW-1:0] : '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      st_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_valid_q  <= st_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_data_i.mode;
      src_q  <= in_data_i.source_node;
      filt_q <= in_data_i.filter_sel;
      idx_q  <= in_idx;
    end
    resp_q <= resp_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = resp_q;

  a_fold_in_fold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_rsp.busy |-> (state_q == ST_FOLD))
    else $error("fold unit busy outside fold state");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
    else $error("result raised without a response state");

  a_coeff_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coeff_we |-> (state_q == ST_IDLE) && !fold_rsp.busy)
    else $error("coefficient written while a command is in flight");

  a_fold_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_rsp.done |=> (state_q == ST_IDLE) && !fold_rsp.busy)
    else $error("fold completion did not return to idle");

endmodule

@@ sim/fir_coefficient_table_command_engine_unit_tb.sv @@
// Self-checking testbench of the FIR coefficient table command engine with random handshakes.
module fir_coefficient_table_command_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_FILTERS = 8;
  localparam int unsigned MAX_LEN     = 128;

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  fctce_pkg::cmd_t  in_data_i;
  logic  out_valid_o;
  logic  out_stall_i;
  fctce_pkg::resp_t out_data_o;

  logic [fctce_pkg::WORD_W-1:0] coeff_mem     [NUM_FILTERS][MAX_LEN];
  bit                           coeff_written [NUM_FILTERS][MAX_LEN];
  logic [fctce_pkg::LEN_W-1:0]  len_tab       [NUM_FILTERS];
  bit                           en_tab        [NUM_FILTERS];
  logic [fctce_pkg::WORD_W-1:0] id_tab        [NUM_FILTERS];

  fctce_pkg::resp_t pending_resp[$];
  int unsigned errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_left = 0;

  fir_coefficient_table_command_engine_unit #(
    .NUM_FILTERS(NUM_FILTERS),
    .MAX_LEN    (MAX_LEN)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("fir_coefficient_table_command_engine_unit: mismatch");
    $finish;
  end

  function automatic int unsigned written_prefix(input int unsigned f);
    int unsigned i;
    i = 0;
    while (i < MAX_LEN && coeff_written[f][i]) i++;
    return i;
  endfunction

  function automatic int unsigned sat_len(input logic [fctce_pkg::HALF_W-1:0] l);
    return (l > MAX_LEN) ? MAX_LEN : l;
  endfunction

  // Apply one accepted command to the table copy; true when it is not dropped.
  function automatic bit apply_cmd(input fctce_pkg::cmd_t c);
    fctce_pkg::resp_t             r;
    int unsigned                  f;
    int unsigned                  n;
    logic [fctce_pkg::WORD_W-1:0] fold;
    f = c.filter_sel;
    if (f >= NUM_FILTERS) return 1'b0;
    r.dest_node   = c.source_node;
    r.resp_filter = c.filter_sel;
    case (c.mode)
      fctce_pkg::MODE_SET_COEFF: begin
        if (c.coeff_index >= MAX_LEN) return 1'b0;
        coeff_mem[f][c.coeff_index]     = {c.value_high, c.value_low};
        coeff_written[f][c.coeff_index] = 1'b1;
      end
      fctce_pkg::MODE_GET_COEFF: begin
        if (c.coeff_index >= MAX_LEN) return 1'b0;
        r.resp_kind              = fctce_pkg::RESP_COEFF;
        r.resp_index_or_len      = c.coeff_index;
        {r.resp_high, r.resp_low} = coeff_mem[f][c.coeff_index];
        pending_resp.push_back(r);
      end
      fctce_pkg::MODE_GET_STATUS: begin
        r.resp_kind              = fctce_pkg::RESP_STATUS;
        r.resp_index_or_len      = {{(fctce_pkg::HALF_W-fctce_pkg::LEN_W){1'b0}}, len_tab[f]};
        {r.resp_high, r.resp_low} = en_tab[f] ? id_tab[f] : '0;
        pending_resp.push_back(r);
      end
      default: begin
        n         = sat_len(c.length);
        len_tab[f] = n[fctce_pkg::LEN_W-1:0];
        en_tab[f]  = c.enable;
        if (c.enable) begin
          fold = '0;
          for (int unsigned i = 0; i < n; i++) fold ^= coeff_mem[f][i];
          id_tab[f] = fold;
        end
      end
    endcase
    return 1'b1;
  endfunction

  // Keep every read of the table on words that have been written.
  function automatic fctce_pkg::cmd_t legalise(input fctce_pkg::cmd_t c);
    int unsigned f;
    f = c.filter_sel;
    if (f < NUM_FILTERS) begin
      if (c.mode == fctce_pkg::MODE_GET_COEFF && c.coeff_index < MAX_LEN &&
          !coeff_written[f][c.coeff_index])
        c.coeff_index[7] = 1'b1;
      if (c.mode == fctce_pkg::MODE_SET_STATUS && c.enable &&
          sat_len(c.length) > written_prefix(f))
        c.enable = 1'b0;
    end
    return c;
  endfunction

  function automatic fctce_pkg::cmd_t rand_cmd();
    fctce_pkg::cmd_t c;
    c.mode        = fctce_pkg::mode_e'($urandom_range(0, 3));
    c.source_node = 8'($urandom_range(0, 255));
    c.filter_sel  = 8'($urandom_range(0, 255));
    c.coeff_index = 16'($urandom_range(0, 65535));
    c.value_high  = 16'($urandom_range(0, 65535));
    c.value_low   = 16'($urandom_range(0, 65535));
    c.enable      = 1'($urandom_range(0, 1));
    c.length      = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  function automatic fctce_pkg::cmd_t mk(input fctce_pkg::mode_e m, input logic [7:0] src,
                                         input logic [7:0] filt, input logic [15:0] idx,
                                         input logic [15:0] hi, input logic [15:0] lo,
                                         input logic en, input logic [15:0] len);
    fctce_pkg::cmd_t c;
    c.mode        = m;
    c.source_node = src;
    c.filter_sel  = filt;
    c.coeff_index = idx;
    c.value_high  = hi;
    c.value_low   = lo;
    c.enable      = en;
    c.length      = len;
    return c;
  endfunction

  task automatic send_cmd(input fctce_pkg::cmd_t c, output bit acted);
    fctce_pkg::cmd_t lc;
    lc = legalise(c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= lc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    acted = apply_cmd(lc);
  endtask

  task automatic send_list(input fctce_pkg::cmd_t cl[$]);
    bit acted;
    foreach (cl[i]) send_cmd(cl[i], acted);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    fctce_pkg::resp_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_resp.size() == 0) begin
        errors++;
        $display("%0t ns: transfer with nothing expected, actual %h", $time, out_data_o);
      end else begin
        exp_r = pending_resp.pop_front();
        check_field("resp_kind", exp_r.resp_kind, out_data_o.resp_kind);
        check_field("dest_node", exp_r.dest_node, out_data_o.dest_node);
        check_field("resp_filter", exp_r.resp_filter, out_data_o.resp_filter);
        check_field("resp_index_or_len", exp_r.resp_index_or_len,
                    out_data_o.resp_index_or_len);
        check_field("resp_high", exp_r.resp_high, out_data_o.resp_high);
        check_field("resp_low", exp_r.resp_low, out_data_o.resp_low);
      end
    end
  end

  task automatic test_reset_status();
    fctce_pkg::cmd_t cl[$];
    for (int unsigned f = 0; f < NUM_FILTERS; f++)
      cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'(f), 8'(f), 16'h0, 16'h0, 16'h0,
                      1'b0, 16'h0));
    send_list(cl);
  endtask

  task automatic test_directed();
    fctce_pkg::cmd_t cl[$];
    cl.push_back(mk(fctce_pkg::MODE_SET_COEFF,  8'h00, 8'd0,   16'd0,    16'hFFFF, 16'hFFFF,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_COEFF,  8'hFF, 8'd0,   16'd1,    16'h0000, 16'h0000,
                    1'b1, 16'hFFFF));
    cl.push_back(mk(fctce_pkg::MODE_SET_COEFF,  8'h5A, 8'd0,   16'd2,    16'h1234, 16'hABCD,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_COEFF,  8'hA5, 8'd7,   16'd127,  16'hFFFF, 16'h0000,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_GET_COEFF,  8'h00, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_GET_COEFF,  8'hFF, 8'd0,   16'd1,    16'hFFFF, 16'hFFFF,
                    1'b1, 16'hFFFF));
    cl.push_back(mk(fctce_pkg::MODE_GET_COEFF,  8'h33, 8'd7,   16'd127,  16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_STATUS, 8'h01, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b1, 16'd3));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h02, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_STATUS, 8'h03, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b1, 16'd0));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h04, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_STATUS, 8'h05, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'hFFFF));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h06, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h07, 8'd8,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h08, 8'd255, 16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_GET_COEFF,  8'h09, 8'd0,   16'd128,  16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_GET_COEFF,  8'h0A, 8'd0,   16'hFFFF, 16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_COEFF,  8'h0B, 8'd0,   16'd128,  16'hDEAD, 16'hBEEF,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_COEFF,  8'h0C, 8'd255, 16'd0,    16'hDEAD, 16'hBEEF,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_STATUS, 8'h0D, 8'd8,   16'd0,    16'h0,    16'h0,
                    1'b1, 16'd1));
    cl.push_back(mk(fctce_pkg::MODE_GET_COEFF,  8'h0E, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_STATUS, 8'h0F, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b1, 16'd2));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h10, 8'd0,   16'd0,    16'h0,    16'h0,
                    1'b0, 16'h0));
    send_list(cl);
  endtask

  task automatic test_full_table();
    fctce_pkg::cmd_t cl[$];
    fctce_pkg::cmd_t c;
    for (int unsigned i = written_prefix(5); i < MAX_LEN; i++) begin
      c = rand_cmd();
      c.mode        = fctce_pkg::MODE_SET_COEFF;
      c.filter_sel  = 8'd5;
      c.coeff_index = 16'(i);
      cl.push_back(c);
    end
    cl.push_back(mk(fctce_pkg::MODE_SET_STATUS, 8'h20, 8'd5, 16'h0, 16'h0, 16'h0,
                    1'b1, 16'hFFFF));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h21, 8'd5, 16'h0, 16'h0, 16'h0,
                    1'b0, 16'h0));
    cl.push_back(mk(fctce_pkg::MODE_SET_STATUS, 8'h22, 8'd5, 16'h0, 16'h0, 16'h0,
                    1'b1, 16'd128));
    cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'h23, 8'd5, 16'h0, 16'h0, 16'h0,
                    1'b0, 16'h0));
    send_list(cl);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned     done_items;
    int unsigned     f;
    int unsigned     p;
    int unsigned     k;
    bit              acted;
    fctce_pkg::cmd_t c;
    done_items = 0;
    while (done_items < n_items) begin
      f = $urandom_range(0, NUM_FILTERS-1);
      p = written_prefix(f);
      c = rand_cmd();
      c.filter_sel = 8'(f);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          c.mode = fctce_pkg::MODE_SET_COEFF;
          if (p == MAX_LEN) begin
            c.coeff_index = 16'($urandom_range(0, MAX_LEN-1));
            send_cmd(c, acted);
            done_items += acted;
          end else begin
            k = $urandom_range(1, 16);
            for (int unsigned i = p; i < p + k && i < MAX_LEN; i++) begin
              c = rand_cmd();
              c.mode        = fctce_pkg::MODE_SET_COEFF;
              c.filter_sel  = 8'(f);
              c.coeff_index = 16'(i);
              send_cmd(c, acted);
              done_items += acted;
            end
          end
        end
        3, 4: begin
          c.mode   = fctce_pkg::MODE_SET_STATUS;
          c.enable = 1'b1;
          c.length = 16'($urandom_range(0, p));
          if (p == MAX_LEN && $urandom_range(0, 1))
            c.length = 16'($urandom_range(MAX_LEN, 65535));
          send_cmd(c, acted);
          done_items += acted;
          c = rand_cmd();
          c.mode       = fctce_pkg::MODE_GET_STATUS;
          c.filter_sel = 8'(f);
          send_cmd(c, acted);
          done_items += acted;
        end
        5, 6: begin
          c.mode        = fctce_pkg::MODE_GET_COEFF;
          c.coeff_index = 16'((p > 0) ? $urandom_range(0, p-1) : $urandom_range(0, MAX_LEN-1));
          send_cmd(c, acted);
          done_items += acted;
        end
        7: begin
          c.mode = fctce_pkg::MODE_GET_STATUS;
          send_cmd(c, acted);
          done_items += acted;
        end
        8: begin
          c.mode   = fctce_pkg::MODE_SET_STATUS;
          c.enable = 1'b0;
          send_cmd(c, acted);
          done_items += acted;
        end
        default: begin
          c = rand_cmd();
          if ($urandom_range(0, 1)) c.coeff_index[15:7] = '0;
          send_cmd(c, acted);
          done_items += acted;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    fctce_pkg::cmd_t cl[$];
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    hold_off_left = 400;
    for (int unsigned i = 0; i < 40; i++)
      cl.push_back(mk(fctce_pkg::MODE_GET_STATUS, 8'(i), 8'(i % NUM_FILTERS), 16'h0, 16'h0,
                      16'h0, 1'b0, 16'h0));
    send_list(cl);
  endtask

  task automatic test_drain_pause();
    drain_results();
    test_reset_status();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    for (int unsigned f = 0; f < NUM_FILTERS; f++) begin
      len_tab[f] = '0;
      en_tab[f]  = 1'b0;
      id_tab[f]  = '0;
      for (int unsigned i = 0; i < MAX_LEN; i++) begin
        coeff_mem[f][i]     = '0;
        coeff_written[f][i] = 1'b0;
      end
    end
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_status();
    test_directed();
    send_idle_pct = 14;
    recv_idle_pct = 61;
    test_random(320);
    test_backpressure();
    send_idle_pct = 61;
    recv_idle_pct = 14;
    test_full_table();
    test_random(320);
    test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(320);

    drain_results();
    repeat (MAX_LEN + 16) @(posedge clk_i);
    if (errors == 0) begin
      $display("fir_coefficient_table_command_engine_unit: match");
    end else begin
      $display("fir_coefficient_table_command_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
